/* hw/rtl/jaf_pkg.sv */
`default_nettype none

package jaf_pkg;

	localparam int SAMPLES      = 4;
	localparam int CORDIC_STEPS = 16;

	localparam int SMP_W = 10;
	localparam int SUM_W = SMP_W + $clog2(SAMPLES);
	localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int LAST  = SAMPLES - 1;

	// centred difference, then CORDIC datapath: 16 fraction bits plus growth
	localparam int DW  = SMP_W + 1;
	localparam int FRC = 16;
	localparam int CW  = DW + FRC + 2;
	localparam int AW  = 32;

	localparam logic [SMP_W-1:0] X_CENTER_RESET  = 10'd488;
	localparam logic [SMP_W-1:0] Y_CENTER_RESET  = 10'd483;
	localparam logic [SMP_W-1:0] DEAD_ZONE_RESET = 10'd31;

	typedef enum logic [1:0] {
		REG_X_CENTER  = 2'd0,
		REG_Y_CENTER  = 2'd1,
		REG_DEAD_ZONE = 2'd2
	} jaf_reg_t;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic                 centered;
		logic                 zero;
	} jaf_vec_t;

	typedef struct packed {
		logic [AW-1:0] acc;
		logic          centered;
		logic          zero;
	} jaf_ang_t;

	// arctangent of 2^-i as a fraction of a turn, 2^32 = full turn
	function automatic logic [AW-1:0] atan_turns(input int i);
		logic [AW-1:0] r;
		case (i)
			0:       r = 32'd536870912;
			1:       r = 32'd316933406;
			2:       r = 32'd167458907;
			3:       r = 32'd85004756;
			4:       r = 32'd42667331;
			5:       r = 32'd21354465;
			6:       r = 32'd10679838;
			7:       r = 32'd5340245;
			8:       r = 32'd2670163;
			9:       r = 32'd1335087;
			10:      r = 32'd667544;
			11:      r = 32'd333772;
			12:      r = 32'd166886;
			13:      r = 32'd83443;
			14:      r = 32'd41722;
			15:      r = 32'd20861;
			16:      r = 32'd10430;
			17:      r = 32'd5215;
			18:      r = 32'd2608;
			19:      r = 32'd1304;
			20:      r = 32'd652;
			21:      r = 32'd326;
			22:      r = 32'd163;
			23:      r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/jaf_accum.sv */
`default_nettype none

module jaf_accum import jaf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_addr,
	input  wire logic [SMP_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [SMP_W-1:0] x_sample,
	input  wire logic [SMP_W-1:0] y_sample,
	output logic                  vec_valid,
	input  wire logic             vec_ready,
	output jaf_vec_t              vec_s1
);

	logic [SMP_W-1:0] x_ctr_q, y_ctr_q, dz_q;
	logic [SUM_W-1:0] x_sum_q, y_sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic             v_s1;

	logic [SUM_W-1:0] x_sum_nxt, y_sum_nxt, x_quo, y_quo;
	logic [SMP_W-1:0] x_avg, y_avg, ax, ay;
	logic signed [DW-1:0] dx, dy, ax_w, ay_w;
	logic             last, take;

	assign last      = (cnt_q == CNT_W'(LAST));
	assign in_ready  = !last || !v_s1 || vec_ready;
	assign take      = in_valid && in_ready;
	assign vec_valid = v_s1;

	always_comb begin
		x_sum_nxt = x_sum_q + SUM_W'(x_sample);
		y_sum_nxt = y_sum_q + SUM_W'(y_sample);
		x_quo     = x_sum_nxt / SUM_W'(SAMPLES);
		y_quo     = y_sum_nxt / SUM_W'(SAMPLES);
		x_avg     = x_quo[SMP_W-1:0];
		y_avg     = y_quo[SMP_W-1:0];
		dx        = $signed({1'b0, x_avg}) - $signed({1'b0, x_ctr_q});
		dy        = $signed({1'b0, y_avg}) - $signed({1'b0, y_ctr_q});
		ax_w      = dx[DW-1] ? -dx : dx;
		ay_w      = dy[DW-1] ? -dy : dy;
		ax        = ax_w[SMP_W-1:0];
		ay        = ay_w[SMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_ctr_q <= X_CENTER_RESET;
			y_ctr_q <= Y_CENTER_RESET;
			dz_q    <= DEAD_ZONE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_X_CENTER:  x_ctr_q <= cfg_wdata;
				REG_Y_CENTER:  y_ctr_q <= cfg_wdata;
				REG_DEAD_ZONE: dz_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_sum_q <= '0;
			y_sum_q <= '0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			if (take) begin
				if (last) begin
					x_sum_q <= '0;
					y_sum_q <= '0;
					cnt_q   <= '0;
				end else begin
					x_sum_q <= x_sum_nxt;
					y_sum_q <= y_sum_nxt;
					cnt_q   <= cnt_q + CNT_W'(1);
				end
			end
			if (!v_s1 || vec_ready) begin
				v_s1 <= take && last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			vec_s1.dx       <= dx;
			vec_s1.dy       <= dy;
			vec_s1.centered <= (ax < dz_q) && (ay < dz_q);
			vec_s1.zero     <= (dx == '0) && (dy == '0);
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LAST))
		else $error("sample count beyond run length");

	a_vec_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(take && last))
		else $error("averaged beat without a completed run");
`endif

endmodule

`default_nettype wire

/* hw/rtl/jaf_cordic.sv */
`default_nettype none

module jaf_cordic import jaf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  jaf_vec_t  in_vec,
	output logic      out_valid,
	input  wire logic out_ready,
	output jaf_ang_t  out_ang
);

	localparam int N = CORDIC_STEPS;

	logic signed [CW-1:0] x_s   [0:N];
	logic signed [CW-1:0] y_s   [0:N];
	logic [AW-1:0]        acc_s [0:N];
	logic                 cen_s [0:N];
	logic                 zr_s  [0:N];
	logic                 v_s   [0:N];
	logic                 rdy   [0:N];

	logic signed [DW-1:0] dx_abs, dy_rot;

	// left half-plane: turn by half a turn first
	assign dx_abs = in_vec.dx[DW-1] ? -in_vec.dx : in_vec.dx;
	assign dy_rot = in_vec.dx[DW-1] ? -in_vec.dy : in_vec.dy;

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			x_s[0]   <= {{(CW-DW-FRC){dx_abs[DW-1]}}, dx_abs, {FRC{1'b0}}};
			y_s[0]   <= {{(CW-DW-FRC){dy_rot[DW-1]}}, dy_rot, {FRC{1'b0}}};
			acc_s[0] <= in_vec.dx[DW-1] ? {1'b1, {(AW-1){1'b0}}} : '0;
			cen_s[0] <= in_vec.centered;
			zr_s[0]  <= in_vec.zero;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic signed [CW-1:0] xs, ys;

		assign xs     = x_s[k] >>> k;
		assign ys     = y_s[k] >>> k;
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (rdy[k+1]) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k+1] && v_s[k]) begin
				if (y_s[k] > 0) begin
					x_s[k+1]   <= x_s[k] + ys;
					y_s[k+1]   <= y_s[k] - xs;
					acc_s[k+1] <= acc_s[k] + atan_turns(k);
				end else begin
					x_s[k+1]   <= x_s[k] - ys;
					y_s[k+1]   <= y_s[k] + xs;
					acc_s[k+1] <= acc_s[k] - atan_turns(k);
				end
				cen_s[k+1] <= cen_s[k];
				zr_s[k+1]  <= zr_s[k];
			end
		end
	end

	assign rdy[N]           = !v_s[N] || out_ready;
	assign out_valid        = v_s[N];
	assign out_ang.acc      = acc_s[N];
	assign out_ang.centered = cen_s[N];
	assign out_ang.zero     = zr_s[N];

endmodule

`default_nettype wire

/* hw/rtl/joystick_angle_from_adc.sv */
// A completed run of SAMPLES pairs passes the averaged-vector register, the CORDIC
// register, one register per CORDIC iteration and the output register. Throughput:
// one input beat per cycle unless stalled; one result beat per SAMPLES input beats.
// Reset (arst_n low) clears sums, sample count and all valid flags, and loads
// the centre and dead-zone registers with their defaults.
`default_nettype none

module joystick_angle_from_adc import jaf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [9:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // x_sample[9:0], y_sample[19:10], zero pad
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // angle_turns[15:0]
	output logic [0:0]       m_axis_tuser    // centered[0]
);

	jaf_vec_t      vec;
	jaf_ang_t      ang;
	logic          vec_valid, vec_ready, ang_valid, ang_ready;
	logic          m_valid_q, cen_q;
	logic [15:0]   angle_q;
	logic [AW-1:0] acc_rnd;

	jaf_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.x_sample  (s_axis_tdata[9:0]),
		.y_sample  (s_axis_tdata[19:10]),
		.vec_valid (vec_valid),
		.vec_ready (vec_ready),
		.vec_s1    (vec)
	);

	jaf_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vec_valid),
		.in_ready  (vec_ready),
		.in_vec    (vec),
		.out_valid (ang_valid),
		.out_ready (ang_ready),
		.out_ang   (ang)
	);

	assign acc_rnd   = ang.acc + AW'(32'h8000);
	assign ang_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ang_ready) begin
			m_valid_q <= ang_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ang_ready && ang_valid) begin
			angle_q <= (ang.centered || ang.zero) ? 16'd0 : acc_rnd[AW-1:AW-16];
			cen_q   <= ang.centered;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = angle_q;
	assign m_axis_tuser[0] = cen_q;

`ifndef SYNTH
	a_centred_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
		else $error("centred beat with non-zero angle");
`endif

endmodule

`default_nettype wire
